// File: rtl/lssp_pkg.sv
// Shared types and constants for the lidar sweep steering policy block.
// No dependencies; imported by the controller, datapath, top level, checker and bench.
`default_nettype none
package lssp_pkg;

    localparam int DIST_W  = 16;
    localparam int TIME_W  = 32;
    localparam int STEER_W = 5;
    localparam int CFG_W   = 32;
    localparam int CFGA_W  = 2;

    // action codes
    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_AVOID  = 2'd1;
    localparam logic [1:0] ACT_ESCAPE = 2'd2;
    localparam logic [1:0] ACT_STEER  = 2'd3;

    // register indexes
    localparam logic [CFGA_W-1:0] CFG_NEAR_MAX = 2'd0;
    localparam logic [CFGA_W-1:0] CFG_NEAR_MIN = 2'd1;
    localparam logic [CFGA_W-1:0] CFG_STUCK    = 2'd2;

    localparam logic [DIST_W-1:0] NEAR_MAX_RST = 16'd40;
    localparam logic [DIST_W-1:0] NEAR_MIN_RST = 16'd5;
    localparam logic [TIME_W-1:0] STUCK_RST    = 32'd3000;

    // controller -> datapath
    typedef struct packed {
        logic load;      // latch input word, settle direction
        logic rw;        // store reading, read entry at longest index
        logic eval;      // classify, update tracking state
        logic scan;      // issue one rescan read
        logic out_load;  // move result into output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_scan;
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// File: rtl/lssp_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module lssp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: rtl/lssp_ctrl.sv
// Sequencing state machine for the steering policy.
// Depends on lssp_pkg (t_cmd, t_sts).
`default_nettype none
module lssp_ctrl
    import lssp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RW    = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RW;
                end
            end
            S_RW: begin
                o_cmd.rw = 1'b1;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_sts.need_scan ? S_SCAN : S_OUT;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last compare of the rescan lands here
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule
`default_nettype wire

// File: rtl/lssp_dpath.sv
// Datapath: config registers, sweep state, reading store and rescan compare.
// Depends on lssp_pkg and lssp_ram.
`default_nettype none
module lssp_dpath
    import lssp_pkg::*;
#(
    parameter int POINTS = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [CFGA_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]   i_cfg_data,
    input  wire logic [DIST_W-1:0]  i_distance_cm,
    input  wire logic [TIME_W-1:0]  i_now_ms,
    input  wire logic               i_out_stall,
    input  wire t_cmd               i_cmd,
    output t_sts                    o_sts,
    output logic                    o_out_valid,
    output logic                    o_sweep_right,
    output logic [1:0]              o_action,
    output logic                    o_avoid_toward_low,
    output logic [STEER_W-1:0]      o_steer_index
);

    localparam int             IW   = $clog2(POINTS);
    localparam logic [IW-1:0]  LAST = IW'(POINTS - 1);
    localparam logic [IW:0]    HALF = (IW+1)'(POINTS / 2);

    // config
    logic [DIST_W-1:0] r_near_max;
    logic [DIST_W-1:0] r_near_min;
    logic [TIME_W-1:0] r_stuck;

    // item and sweep state
    logic [DIST_W-1:0] r_dist;
    logic [TIME_W-1:0] r_now;
    logic [IW-1:0]     r_pos;
    logic              r_right;
    logic [IW-1:0]     r_long;
    logic              r_near_act;
    logic [TIME_W-1:0] r_near_since;
    logic [POINTS-1:0] r_valid;
    logic              r_rd_valid;
    logic [1:0]        r_action;
    logic              r_low;

    // rescan
    logic [IW-1:0]     r_scan_addr;
    logic [IW-1:0]     r_cmp_addr;
    logic              r_cmp_vld;
    logic              r_cmp_valid_bit;
    logic [DIST_W-1:0] r_best;

    // output register
    logic              r_out_valid;
    logic              r_out_right;
    logic [1:0]        r_out_action;
    logic              r_out_low;
    logic [IW-1:0]     r_out_long;

    logic              ram_we;
    logic [IW-1:0]     ram_raddr;
    logic [DIST_W-1:0] ram_rdata;

    logic [DIST_W-1:0] long_val;
    logic [DIST_W-1:0] scan_val;
    logic [TIME_W-1:0] elapsed;
    logic              is_near;
    logic              is_max;

    lssp_ram #(
        .WIDTH (DIST_W),
        .DEPTH (POINTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pos),
        .i_wdata (r_dist),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ram_we    = i_cmd.rw;
    assign ram_raddr = i_cmd.scan ? r_scan_addr : r_long;

    // entries never written read as zero
    assign long_val = (r_long == r_pos) ? r_dist : (r_rd_valid ? ram_rdata : '0);
    assign scan_val = r_cmp_valid_bit ? ram_rdata : '0;
    assign elapsed  = r_now - r_near_since;
    assign is_near  = (r_dist < r_near_max) && (r_dist > r_near_min);
    assign is_max   = (r_dist > long_val);

    assign o_sts.need_scan = !is_near && !is_max && (r_pos == r_long);
    assign o_sts.scan_last = (r_scan_addr == LAST);
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_max <= NEAR_MAX_RST;
            r_near_min <= NEAR_MIN_RST;
            r_stuck    <= STUCK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NEAR_MAX: r_near_max <= i_cfg_data[DIST_W-1:0];
                CFG_NEAR_MIN: r_near_min <= i_cfg_data[DIST_W-1:0];
                CFG_STUCK:    r_stuck    <= i_cfg_data[TIME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // control and sweep state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_right      <= 1'b1;
            r_long       <= '0;
            r_near_act   <= 1'b0;
            r_near_since <= '0;
            r_valid      <= '0;
            r_cmp_vld    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (r_pos == LAST) begin
                    r_right <= 1'b0;
                end else if (r_pos <= IW'(1)) begin
                    r_right <= 1'b1;
                end
            end
            if (i_cmd.rw) begin
                r_valid[r_pos] <= 1'b1;
            end
            if (i_cmd.eval) begin
                if (is_near) begin
                    if (!r_near_act) begin
                        r_near_act   <= 1'b1;
                        r_near_since <= r_now;
                    end
                end else begin
                    r_near_act <= 1'b0;
                    if (is_max) begin
                        r_long <= r_pos;
                    end
                end
                if (r_right) begin
                    r_pos <= r_pos + 1'b1;
                end else if (r_pos != '0) begin
                    r_pos <= r_pos - 1'b1;
                end
            end
            r_cmp_vld <= i_cmd.scan;
            if (r_cmp_vld && (scan_val > r_best)) begin
                r_long <= r_cmp_addr;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dist <= i_distance_cm;
            r_now  <= i_now_ms;
        end
        if (i_cmd.rw) begin
            r_rd_valid <= r_valid[r_long];
        end
        if (i_cmd.eval) begin
            r_best      <= '0;
            r_scan_addr <= '0;
            r_low       <= is_near && ({1'b0, r_pos} < HALF);
            if (is_near) begin
                r_action <= (r_near_act && (elapsed > r_stuck)) ? ACT_ESCAPE : ACT_AVOID;
            end else if (is_max) begin
                r_action <= ACT_STEER;
            end else begin
                r_action <= ACT_NONE;
            end
        end
        if (i_cmd.scan) begin
            r_scan_addr     <= r_scan_addr + 1'b1;
            r_cmp_addr      <= r_scan_addr;
            r_cmp_valid_bit <= r_valid[r_scan_addr];
        end
        if (r_cmp_vld && (scan_val > r_best)) begin
            r_best <= scan_val;
        end
        if (i_cmd.out_load) begin
            r_out_right  <= r_right;
            r_out_action <= r_action;
            r_out_low    <= r_low;
            r_out_long   <= r_long;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_sweep_right      = r_out_right;
    assign o_action           = r_out_action;
    assign o_avoid_toward_low = r_out_low;

    generate
        if (IW >= STEER_W) begin : g_steer_trunc
            assign o_steer_index = r_out_long[STEER_W-1:0];
        end else begin : g_steer_ext
            assign o_steer_index = {{(STEER_W-IW){1'b0}}, r_out_long};
        end
    endgenerate

endmodule
`default_nettype wire

// File: rtl/lidar_sweep_steering_policy_core.sv
// Lidar sweep steering policy, top level. One word in flight at a time.
// Each word goes through load, store and read, evaluate, an optional rescan with
// its drain, and output; the rescan reads the reading store one entry per cycle
// through its single read port.
// Reset (synchronous, active low): config to 40/5/3000, store reads as zero
// through per-entry valid flops, position 0, direction right, no clearing pass.
`default_nettype none
module lidar_sweep_steering_policy_core
    import lssp_pkg::*;
#(
    parameter int POINTS = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CFGA_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [DIST_W-1:0] i_distance_cm,
    input  wire logic [TIME_W-1:0] i_now_ms,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic                   o_sweep_right,
    output logic [1:0]             o_action,
    output logic                   o_avoid_toward_low,
    output logic [STEER_W-1:0]     o_steer_index
);

    t_cmd cmd;
    t_sts sts;

    lssp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lssp_dpath #(
        .POINTS (POINTS)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_distance_cm      (i_distance_cm),
        .i_now_ms           (i_now_ms),
        .i_out_stall        (i_out_stall),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .o_out_valid        (o_out_valid),
        .o_sweep_right      (o_sweep_right),
        .o_action           (o_action),
        .o_avoid_toward_low (o_avoid_toward_low),
        .o_steer_index      (o_steer_index)
    );

endmodule
`default_nettype wire

// File: rtl/lssp_checker.sv
// Port-level checks for the steering policy core, bound to the top level.
// Depends on lssp_pkg and lidar_sweep_steering_policy_core.
`default_nettype none
module lssp_checker
    import lssp_pkg::*;
#(
    parameter int POINTS = 32
) (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_stall,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire logic              o_sweep_right,
    input wire logic [1:0]        o_action,
    input wire logic              o_avoid_toward_low,
    input wire logic [STEER_W-1:0] o_steer_index
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_action)
            && $stable(o_steer_index) && $stable(o_sweep_right)
            && $stable(o_avoid_toward_low))
        else $error("stalled output word changed");

    // one word in flight: accepting stalls the input side next cycle
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted while previous word still in work");

    // turn flag only accompanies an avoid or escape request
    a_low_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_avoid_toward_low |-> (o_action == ACT_AVOID)
            || (o_action == ACT_ESCAPE))
        else $error("turn flag set without avoid action");

    // steering index stays within the sweep
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_steer_index) <= 32'(POINTS - 1)))
        else $error("steer index beyond last position");

endmodule

bind lidar_sweep_steering_policy_core lssp_checker #(.POINTS(POINTS)) u_lssp_checker (.*);
`default_nettype wire

// File: tb/sv/tb_lidar_sweep_steering_policy_core.sv
// Self-checking bench for lidar_sweep_steering_policy_core: directed table, then random phases
// over several limit settings, each output word checked against its table entry or an in-bench sweep predictor.
// Depends on lssp_pkg and the core RTL only.
module tb_lidar_sweep_steering_policy_core;
    timeunit 1ns;
    timeprecision 1ps;
    import lssp_pkg::*;

    localparam int NPTS           = 32;
    localparam int NDIR           = 19;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int SQUEEZE_CYCLES = 300;
    localparam logic [CFGA_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic               sweep_right;
        logic [1:0]         action;
        logic               toward_low;
        logic [STEER_W-1:0] steer;
    } t_steer_word;

    typedef struct packed {
        logic [DIST_W-1:0] dist_cm;
        logic [TIME_W-1:0] now;
        logic              typed;
        t_steer_word       want;
    } t_plan_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [CFGA_W-1:0]  i_cfg_index = '0;
    logic [CFG_W-1:0]   i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [DIST_W-1:0]  i_distance_cm = '0;
    logic [TIME_W-1:0]  i_now_ms = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_sweep_right;
    logic [1:0]         o_action;
    logic               o_avoid_toward_low;
    logic [STEER_W-1:0] o_steer_index;

    lidar_sweep_steering_policy_core #(.POINTS(NPTS)) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_distance_cm      (i_distance_cm),
        .i_now_ms           (i_now_ms),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_sweep_right      (o_sweep_right),
        .o_action           (o_action),
        .o_avoid_toward_low (o_avoid_toward_low),
        .o_steer_index      (o_steer_index)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state and limits
    logic [DIST_W-1:0] store_cm [NPTS];
    int unsigned       sweep_pos;
    int unsigned       best_idx;
    logic              heading_right;
    logic              near_on;
    logic [TIME_W-1:0] near_t0;
    logic [DIST_W-1:0] lim_hi;
    logic [DIST_W-1:0] lim_lo;
    logic [TIME_W-1:0] stuck_limit;

    t_steer_word       awaited [$];
    t_plan_row         plan [NDIR];
    int                fault_count = 0;
    int                cycle_count = 0;
    bit                idle_en = 1'b1;
    bit                squeeze_req = 1'b0;
    logic [TIME_W-1:0] clock_ms;
    int                near_left;

    task automatic reset_model();
        for (int k = 0; k < NPTS; k++) store_cm[k] = '0;
        sweep_pos     = 0;
        best_idx      = 0;
        heading_right = 1'b1;
        near_on       = 1'b0;
        near_t0       = '0;
        lim_hi        = NEAR_MAX_RST;
        lim_lo        = NEAR_MIN_RST;
        stuck_limit   = STUCK_RST;
    endtask

    task automatic advance_sweep(input logic [DIST_W-1:0] dist_cm,
                                 input logic [TIME_W-1:0] now,
                                 output t_steer_word res);
        int unsigned       pos;
        logic [DIST_W-1:0] peak;
        logic [TIME_W-1:0] held;
        res = '0;
        if (sweep_pos >= NPTS - 1)
            heading_right = 1'b0;
        else if (sweep_pos <= 1)
            heading_right = 1'b1;
        pos = sweep_pos;
        store_cm[pos] = dist_cm;
        if (dist_cm < lim_hi && dist_cm > lim_lo) begin
            held = now - near_t0;
            if (near_on && held > stuck_limit)
                res.action = ACT_ESCAPE;
            else
                res.action = ACT_AVOID;
            res.toward_low = (pos < NPTS / 2);
            if (!near_on) begin
                near_on = 1'b1;
                near_t0 = now;
            end
        end else begin
            near_on = 1'b0;
            if (store_cm[pos] > store_cm[best_idx]) begin
                best_idx   = pos;
                res.action = ACT_STEER;
            end else if (pos == best_idx) begin
                // old maximum rewritten without growing: first strictly largest nonzero entry wins
                peak = '0;
                for (int k = 0; k < NPTS; k++) begin
                    if (store_cm[k] > peak) begin
                        peak     = store_cm[k];
                        best_idx = k;
                    end
                end
            end
        end
        res.sweep_right = heading_right;
        res.steer       = STEER_W'(best_idx);
        if (heading_right)
            sweep_pos = pos + 1;
        else if (pos > 0)
            sweep_pos = pos - 1;
    endtask

    task automatic write_reg(input logic [CFGA_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_NEAR_MAX: lim_hi = data[DIST_W-1:0];
            CFG_NEAR_MIN: lim_lo = data[DIST_W-1:0];
            CFG_STUCK:    stuck_limit = data;
            default: ;
        endcase
    endtask

    // Offer one word; valid stays high across back-to-back words.
    task automatic send_word(input logic [DIST_W-1:0] dist_cm, input logic [TIME_W-1:0] now,
                             input logic typed, input t_steer_word want);
        int          r;
        int          gap;
        t_steer_word calc;
        r   = $urandom_range(0, 99);
        gap = 0;
        if (idle_en && r >= 50)
            gap = (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_distance_cm <= dist_cm;
        i_now_ms      <= now;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        advance_sweep(dist_cm, now, calc);
        awaited.push_back(typed ? want : calc);
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (awaited.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Near runs of random length, otherwise zeros, maxima, limit values, ties and noise.
    task automatic pick_reading(output logic [DIST_W-1:0] dist_cm,
                                output logic [TIME_W-1:0] now);
        int r;
        r = $urandom_range(0, 99);
        if (near_left == 0 && r < 25)
            near_left = $urandom_range(1, 8);
        if (near_left > 0) begin
            near_left--;
            if (lim_hi > lim_lo + 1)
                dist_cm = DIST_W'($urandom_range(lim_lo + 1, lim_hi - 1));
            else
                dist_cm = DIST_W'($urandom_range(0, 65535));
        end else if (r < 35)
            dist_cm = '0;
        else if (r < 42)
            dist_cm = '1;
        else if (r < 50)
            dist_cm = $urandom_range(0, 1) ? lim_hi : lim_lo;
        else if (r < 65)
            dist_cm = DIST_W'(100 * $urandom_range(1, 3));
        else
            dist_cm = DIST_W'($urandom_range(0, 65535));
        if ($urandom_range(0, 99) < 95)
            clock_ms = clock_ms + $urandom_range(0, 1500);
        else
            clock_ms = clock_ms + $urandom;
        now = clock_ms;
    endtask

    task automatic run_phase(input int n, input int squeeze_at);
        logic [DIST_W-1:0] d;
        logic [TIME_W-1:0] t;
        for (int k = 0; k < n; k++) begin
            if (k == squeeze_at)
                squeeze_req = 1'b1;
            pick_reading(d, t);
            send_word(d, t, 1'b0, '0);
        end
        settle();
    endtask

    // output side: random stall stretches (none while idling is off), plus one long squeeze on request
    initial begin
        int   r;
        int   stretch;
        logic hold;
        stretch = 0;
        hold    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (squeeze_req) begin
                squeeze_req = 1'b0;
                hold        = 1'b1;
                stretch     = SQUEEZE_CYCLES;
            end else if (stretch <= 0) begin
                r = $urandom_range(0, 99);
                if (!idle_en) begin
                    hold    = 1'b0;
                    stretch = 1;
                end else if (r < 30) begin
                    hold    = 1'b1;
                    stretch = $urandom_range(1, 4);
                end else if (r < 34) begin
                    hold    = 1'b1;
                    stretch = $urandom_range(20, 60);
                end else begin
                    hold    = 1'b0;
                    stretch = $urandom_range(1, 12);
                end
            end
            i_out_stall <= hold;
            stretch--;
        end
    end

    always @(posedge i_clk) begin
        t_steer_word head;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited.size() == 0) begin
                $display("%0t: unexpected output word right=%0d action=%0d low=%0d steer=%0d",
                         $time, o_sweep_right, o_action, o_avoid_toward_low, o_steer_index);
                fault_count++;
            end else begin
                head = awaited.pop_front();
                if (o_sweep_right !== head.sweep_right) begin
                    $display("%0t: sweep_right expected %0d got %0d",
                             $time, head.sweep_right, o_sweep_right);
                    fault_count++;
                end
                if (o_action !== head.action) begin
                    $display("%0t: action expected %0d got %0d", $time, head.action, o_action);
                    fault_count++;
                end
                if (o_avoid_toward_low !== head.toward_low) begin
                    $display("%0t: avoid_toward_low expected %0d got %0d",
                             $time, head.toward_low, o_avoid_toward_low);
                    fault_count++;
                end
                if (o_steer_index !== head.steer) begin
                    $display("%0t: steer_index expected %0d got %0d",
                             $time, head.steer, o_steer_index);
                    fault_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        logic [DIST_W-1:0] lo;
        logic [DIST_W-1:0] hi;
        // dist_cm, now, typed, {sweep_right, action, toward_low, steer}
        plan = '{
            '{16'd0,     32'd0,         1'b1, '{1'b1, ACT_NONE,   1'b0, 5'd0}}, // empty store
            '{16'd20,    32'd100,       1'b1, '{1'b1, ACT_AVOID,  1'b1, 5'd0}},
            '{16'd39,    32'd3100,      1'b1, '{1'b1, ACT_AVOID,  1'b1, 5'd0}}, // elapsed == stuck
            '{16'd6,     32'd3101,      1'b1, '{1'b1, ACT_ESCAPE, 1'b1, 5'd0}},
            '{16'd40,    32'd3102,      1'b1, '{1'b1, ACT_STEER,  1'b0, 5'd4}}, // at near_max
            '{16'd5,     32'd3200,      1'b1, '{1'b1, ACT_NONE,   1'b0, 5'd4}}, // at near_min
            '{16'hFFFF,  32'hFFFF_FFFF, 1'b1, '{1'b1, ACT_STEER,  1'b0, 5'd6}},
            '{16'd10,    32'hFFFF_FF00, 1'b1, '{1'b1, ACT_AVOID,  1'b1, 5'd6}},
            '{16'd11,    32'h0000_0BB9, 1'b1, '{1'b1, ACT_ESCAPE, 1'b1, 5'd6}}, // time wraps
            '{16'd12,    32'h0000_0BBA, 1'b1, '{1'b1, ACT_ESCAPE, 1'b1, 5'd6}}, // escape again
            '{16'd0,     32'h0000_0BBB, 1'b1, '{1'b1, ACT_NONE,   1'b0, 5'd6}},
            '{16'd30,    32'h0000_0BBC, 1'b1, '{1'b1, ACT_AVOID,  1'b1, 5'd6}},
            '{16'd1000,  32'h0000_1000, 1'b0, '0},
            '{16'hAAAA,  32'h5555_5555, 1'b0, '0},
            '{16'h5555,  32'hAAAA_AAAA, 1'b0, '0},
            '{16'd100,   32'h0000_2000, 1'b0, '0},
            '{16'd25,    32'h0000_2100, 1'b1, '{1'b1, ACT_AVOID,  1'b0, 5'd6}}, // upper half
            '{16'hFFFF,  32'h3000_0000, 1'b1, '{1'b1, ACT_NONE,   1'b0, 5'd6}}, // tie keeps old
            '{16'd8,     32'h3000_0001, 1'b0, '0}
        };
        reset_model();
        near_left = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < NDIR; k++)
            send_word(plan[k].dist_cm, plan[k].now, plan[k].typed, plan[k].want);
        settle();

        clock_ms = 32'd20000;
        run_phase(90, -1);

        // widest window, escape on the second near word; no idling
        write_reg(CFG_NEAR_MAX, 32'hFFFF_FFFF);
        write_reg(CFG_NEAR_MIN, 32'h0000_0000);
        write_reg(CFG_STUCK, 32'h0000_0000);
        idle_en = 1'b0;
        run_phase(80, -1);
        idle_en = 1'b1;

        // inverted limits: nothing is near
        write_reg(CFG_NEAR_MAX, 32'h0000_0000);
        write_reg(CFG_NEAR_MIN, 32'h0000_FFFF);
        write_reg(CFG_STUCK, 32'hFFFF_FFFF);
        run_phase(60, -1);

        write_reg(CFG_NEAR_MAX, 32'd100);
        write_reg(CFG_NEAR_MIN, 32'd100);
        run_phase(20, -1);

        // narrow window, short stuck time, time near wrap; output side squeezed
        write_reg(CFG_NEAR_MAX, 32'd200);
        write_reg(CFG_NEAR_MIN, 32'd50);
        write_reg(CFG_STUCK, 32'd500);
        clock_ms = 32'hFFFF_F000;
        run_phase(90, 15);

        repeat (3) begin
            lo = DIST_W'($urandom_range(0, 2000));
            hi = lo + DIST_W'($urandom_range(0, 3000));
            write_reg(CFG_UNUSED, $urandom);
            write_reg(CFG_NEAR_MIN, {16'($urandom), lo});
            write_reg(CFG_NEAR_MAX, {16'($urandom), hi});
            write_reg(CFG_STUCK, $urandom_range(0, 6000));
            run_phase(40, -1);
        end

        repeat (NPTS + 8) @(posedge i_clk);
        if (fault_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: lidar_sweep_steering_policy_core.f
rtl/lssp_pkg.sv
rtl/lssp_ram.sv
rtl/lssp_ctrl.sv
rtl/lssp_dpath.sv
rtl/lidar_sweep_steering_policy_core.sv
rtl/lssp_checker.sv
tb/sv/tb_lidar_sweep_steering_policy_core.sv
